/* rtl/mxau_pkg.sv */
// Shared types, codes, saturation helpers and transpose index helpers for the 4x4 matrix arithmetic unit.
package mxau_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = 4;
  localparam int DEPTH     = 16;

  // Action codes as they arrive on the command port
  localparam logic [3:0] ACT_WRA   = 4'd0;
  localparam logic [3:0] ACT_WRB   = 4'd1;
  localparam logic [3:0] ACT_RD    = 4'd2;
  localparam logic [3:0] ACT_ID    = 4'd3;
  localparam logic [3:0] ACT_TR    = 4'd4;
  localparam logic [3:0] ACT_ADD   = 4'd5;
  localparam logic [3:0] ACT_SUB   = 4'd6;
  localparam logic [3:0] ACT_MUL   = 4'd7;
  localparam logic [3:0] ACT_SCALE = 4'd8;
  // Internal step kinds beyond the action codes
  localparam logic [3:0] KIND_NONE  = 4'd9;
  localparam logic [3:0] KIND_LOAD  = 4'd10;
  localparam logic [3:0] KIND_MAC   = 4'd11;
  localparam logic [3:0] KIND_CLEAR = 4'd12;

  localparam logic [WORD_W-1:0] ONE_Q = WORD_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] MAX_Q = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] MIN_Q = {1'b1, {(WORD_W-1){1'b0}}};

  // One memory step issued by the sequencer
  typedef struct packed {
    logic              valid;
    logic [3:0]        kind;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [ADDR_W-1:0] waddr;
    logic [1:0]        k;
    logic              first;
    logic              last;
    logic              done;
  } iss_t;

  // Write-back to the two matrix memories
  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic [WORD_W-1:0] v;
    logic              ov;
  } sat_t;

  // Scale a magnitude product back by FRAC_BITS, apply sign, saturate
  function automatic sat_t sat_prod(input logic [2*WORD_W-1:0] p, input logic neg);
    logic [2*WORD_W-FRAC_BITS-1:0] sh;
    sat_t r;
    sh   = p[2*WORD_W-1:FRAC_BITS];
    r.ov = 1'b0;
    r.v  = '0;
    if (!neg) begin
      if (sh > (2*WORD_W-FRAC_BITS)'(MAX_Q)) begin
        r.v  = MAX_Q;
        r.ov = 1'b1;
      end else begin
        r.v = sh[WORD_W-1:0];
      end
    end else begin
      if (sh > (2*WORD_W-FRAC_BITS)'(MIN_Q)) begin
        r.v  = MIN_Q;
        r.ov = 1'b1;
      end else begin
        r.v = ~sh[WORD_W-1:0] + WORD_W'(1);
      end
    end
    return r;
  endfunction

  // Saturate a wide signed sum to the element width
  function automatic sat_t clamp_wide(input logic signed [WORD_W+1:0] s);
    sat_t r;
    r.ov = 1'b0;
    r.v  = s[WORD_W-1:0];
    if (s > $signed({2'b00, MAX_Q})) begin
      r.v  = MAX_Q;
      r.ov = 1'b1;
    end else if (s < $signed({2'b11, MIN_Q})) begin
      r.v  = MIN_Q;
      r.ov = 1'b1;
    end
    return r;
  endfunction

  // Off-diagonal pairs swapped by a transpose
  function automatic logic [ADDR_W-1:0] tr_lo(input logic [2:0] p);
    logic [ADDR_W-1:0] r;
    case (p)
      3'd0:    r = 4'd1;
      3'd1:    r = 4'd2;
      3'd2:    r = 4'd3;
      3'd3:    r = 4'd6;
      3'd4:    r = 4'd7;
      default: r = 4'd11;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] tr_hi(input logic [ADDR_W-1:0] lo);
    return {lo[1:0], lo[3:2]};
  endfunction

endpackage

/* rtl/mxau_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module mxau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mxau_seq.sv */
// Step sequencer: turns one command into a stream of memory steps.
module mxau_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [3:0]           action,
  input  logic [1:0]           row,
  input  logic [1:0]           col,
  output logic                 running,
  output mxau_pkg::iss_t       iss
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0] state;
  logic [3:0] act;
  logic [3:0] idx;
  logic [4:0] cnt;
  logic [1:0] mrow;
  logic [3:0] m;
  logic [3:0] tlo;

  assign running = (state != ST_IDLE);
  assign m       = 4'(cnt - 5'd4);
  assign tlo     = mxau_pkg::tr_lo(cnt[3:1]);

  // Step decode
  always_comb begin
    iss       = '0;
    iss.valid = (state != ST_IDLE);
    iss.kind  = mxau_pkg::KIND_NONE;
    unique case (state)
      ST_CLEAR: begin
        iss.kind  = mxau_pkg::KIND_CLEAR;
        iss.waddr = cnt[3:0];
      end
      ST_RUN: begin
        case (act) inside
          mxau_pkg::ACT_WRA, mxau_pkg::ACT_WRB, mxau_pkg::ACT_RD: begin
            iss.kind    = act;
            iss.raddr_a = idx;
            iss.waddr   = idx;
            iss.done    = 1'b1;
          end
          mxau_pkg::ACT_ID: begin
            iss.kind  = act;
            iss.waddr = cnt[3:0];
            iss.done  = (cnt[3:0] == 4'd15);
          end
          mxau_pkg::ACT_TR: begin
            // for each pair, the even step reads the low element and writes it high; the odd step the reverse
            iss.kind    = act;
            iss.raddr_a = cnt[0] ? mxau_pkg::tr_hi(tlo) : tlo;
            iss.waddr   = cnt[0] ? tlo : mxau_pkg::tr_hi(tlo);
            iss.done    = (cnt[3:0] == 4'd11);
          end
          mxau_pkg::ACT_ADD, mxau_pkg::ACT_SUB, mxau_pkg::ACT_SCALE: begin
            iss.kind    = act;
            iss.raddr_a = cnt[3:0];
            iss.raddr_b = cnt[3:0];
            iss.waddr   = cnt[3:0];
            iss.done    = (cnt[3:0] == 4'd15);
          end
          mxau_pkg::ACT_MUL: begin
            if (cnt < 5'd4) begin
              // load the row of A into the operand registers
              iss.kind    = mxau_pkg::KIND_LOAD;
              iss.raddr_a = {mrow, cnt[1:0]};
              iss.k       = cnt[1:0];
            end else begin
              iss.kind    = mxau_pkg::KIND_MAC;
              iss.raddr_b = {m[1:0], m[3:2]};
              iss.waddr   = {mrow, m[3:2]};
              iss.k       = m[1:0];
              iss.first   = (m[1:0] == 2'd0);
              iss.last    = (m[1:0] == 2'd3);
              iss.done    = (mrow == 2'd3) && (cnt == 5'd19);
            end
          end
          default: begin
            iss.kind = mxau_pkg::KIND_NONE;
            iss.done = 1'b1;
          end
        endcase
      end
      default: begin
        iss.valid = 1'b0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      mrow  <= '0;
      act   <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
            act   <= action;
            idx   <= {row, col};
            cnt   <= '0;
            mrow  <= '0;
          end
        end
        ST_CLEAR: begin
          cnt <= cnt + 5'd1;
          if (cnt[3:0] == 4'd15) begin
            state <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (iss.done) begin
            state <= ST_IDLE;
          end else if (act == mxau_pkg::ACT_MUL && cnt == 5'd19) begin
            cnt  <= '0;
            mrow <= mrow + 2'd1;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/mxau_alu.sv */
// Read-data stage, shared multiplier/adder stage and write-back of the matrix unit.
module mxau_alu (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic signed [mxau_pkg::WORD_W-1:0] value,
  input  mxau_pkg::iss_t                    iss,
  input  logic [mxau_pkg::WORD_W-1:0]       rdata_a,
  input  logic [mxau_pkg::WORD_W-1:0]       rdata_b,
  output mxau_pkg::wr_t                     wr,
  output logic                              pipe_busy,
  output logic                              valid,
  output logic [mxau_pkg::WORD_W-1:0]       rd_out,
  output logic                              ov_out,
  output logic [3:0]                        kind_out
);

  localparam int W = mxau_pkg::WORD_W;

  mxau_pkg::iss_t tag1, tag2;
  logic              v1, v2;
  logic [W-1:0]      value_q;
  logic [W-1:0]      arow [4];
  logic [W-1:0]      op_a, op_b;
  logic [W-1:0]      mag_a, mag_b;
  logic [2*W-1:0]    prod;
  logic              neg2;
  logic signed [W:0] sum2;
  logic [W-1:0]      data2;
  logic signed [W+1:0] acc, acc_next;
  logic              ov_acc;
  mxau_pkg::sat_t    sp, sc, sa;
  logic              ov_now;

  // Operand select for the shared multiplier
  always_comb begin
    op_a  = (tag1.kind == mxau_pkg::KIND_MAC) ? arow[tag1.k] : rdata_a;
    op_b  = (tag1.kind == mxau_pkg::KIND_MAC) ? rdata_b : value_q;
    mag_a = op_a[W-1] ? (~op_a + W'(1)) : op_a;
    mag_b = op_b[W-1] ? (~op_b + W'(1)) : op_b;
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= iss.valid;
      v2 <= v1;
    end
  end

  // Stage payload: product, sum and raw read data
  always_ff @(posedge clk) begin
    tag1  <= iss;
    tag2  <= tag1;
    prod  <= mag_a * mag_b;
    neg2  <= op_a[W-1] ^ op_b[W-1];
    data2 <= rdata_a;
    if (tag1.kind == mxau_pkg::ACT_SUB) begin
      sum2 <= $signed({rdata_a[W-1], rdata_a}) - $signed({rdata_b[W-1], rdata_b});
    end else begin
      sum2 <= $signed({rdata_a[W-1], rdata_a}) + $signed({rdata_b[W-1], rdata_b});
    end
    if (v1 && tag1.kind == mxau_pkg::KIND_LOAD) begin
      arow[tag1.k] <= rdata_a;
    end
    if (accept) begin
      value_q <= value;
    end
  end

  // Saturation and accumulate
  always_comb begin
    sp       = mxau_pkg::sat_prod(prod, neg2);
    sc       = mxau_pkg::clamp_wide({sum2[W], sum2});
    acc_next = (tag2.first ? '0 : acc) + {{2{sp.v[W-1]}}, sp.v};
    sa       = mxau_pkg::clamp_wide(acc_next);
  end

  // Write-back decode
  always_comb begin
    wr      = '0;
    wr.addr = tag2.waddr;
    ov_now  = 1'b0;
    case (tag2.kind)
      mxau_pkg::ACT_WRA: begin
        wr.we_a = v2;
        wr.data = value_q;
      end
      mxau_pkg::ACT_WRB: begin
        wr.we_b = v2;
        wr.data = value_q;
      end
      mxau_pkg::ACT_ID: begin
        wr.we_a = v2;
        wr.data = (tag2.waddr[1:0] == tag2.waddr[3:2]) ? mxau_pkg::ONE_Q : '0;
      end
      mxau_pkg::ACT_TR: begin
        wr.we_a = v2;
        wr.data = data2;
      end
      mxau_pkg::ACT_ADD, mxau_pkg::ACT_SUB: begin
        wr.we_a = v2;
        wr.data = sc.v;
        ov_now  = sc.ov;
      end
      mxau_pkg::ACT_SCALE: begin
        wr.we_a = v2;
        wr.data = sp.v;
        ov_now  = sp.ov;
      end
      mxau_pkg::KIND_MAC: begin
        wr.we_a = v2 && tag2.last;
        wr.data = sa.v;
        ov_now  = sp.ov || (tag2.last && sa.ov);
      end
      mxau_pkg::KIND_CLEAR: begin
        wr.we_a = v2;
        wr.we_b = v2;
        wr.data = '0;
      end
      default: begin
        wr.data = '0;
      end
    endcase
  end

  // Accumulator and sticky overflow
  always_ff @(posedge clk) begin
    if (v2 && tag2.kind == mxau_pkg::KIND_MAC) begin
      acc <= acc_next;
    end
    if (rst || accept) begin
      ov_acc <= 1'b0;
    end else if (v2 && ov_now) begin
      ov_acc <= 1'b1;
    end
  end

  assign pipe_busy = v1 || v2;
  assign valid     = v2 && tag2.done && (tag2.kind != mxau_pkg::KIND_CLEAR);
  assign rd_out    = (tag2.kind == mxau_pkg::ACT_RD) ? data2 : '0;
  assign ov_out    = ov_acc || ov_now;
  assign kind_out  = tag2.kind;

endmodule

/* rtl/matrix4x4_arithmetic_unit.sv */
// Top level of the 4x4 Q16.16 matrix arithmetic unit: sequencer, datapath and two memories.
// One transaction at a time; the next can be accepted in the cycle after the result.
// The multiply is bound by one shared multiplier fed from the B memory read port.
// Reset (synchronous) runs a clearing pass over both memories, and busy stays high until it is done.
// The result strobe lasts one cycle and the receiver cannot stall.
module matrix4x4_arithmetic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         action,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic signed [31:0] value,
  output logic               valid,
  output logic signed [31:0] read_value,
  output logic               overflow
);

  localparam int W = mxau_pkg::WORD_W;

  mxau_pkg::iss_t iss;
  mxau_pkg::wr_t  wr;
  logic           accept;
  logic           running;
  logic           pipe_busy;
  logic [W-1:0]   rdata_a, rdata_b;
  logic [W-1:0]   rd_out;
  logic [3:0]     kind_out;

  assign busy       = running || pipe_busy;
  assign accept     = start && !busy;
  assign read_value = rd_out;

  mxau_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .action  (action),
    .row     (row),
    .col     (col),
    .running (running),
    .iss     (iss)
  );

  mxau_ram #(.WIDTH(W), .DEPTH(mxau_pkg::DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (wr.we_a),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (iss.raddr_a),
    .rdata (rdata_a)
  );

  mxau_ram #(.WIDTH(W), .DEPTH(mxau_pkg::DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (wr.we_b),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (iss.raddr_b),
    .rdata (rdata_b)
  );

  mxau_alu u_alu (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .value     (value),
    .iss       (iss),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .wr        (wr),
    .pipe_busy (pipe_busy),
    .valid     (valid),
    .rd_out    (rd_out),
    .ov_out    (overflow),
    .kind_out  (kind_out)
  );

`ifndef SYNTHESIS
  a_strobe_ends_busy: assert property (@(posedge clk) disable iff (rst)
    valid |=> !busy) else $error("busy still high after result");
  a_strobe_needs_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> busy) else $error("result without a transaction in flight");
  a_read_no_ov: assert property (@(posedge clk) disable iff (rst)
    valid && kind_out == mxau_pkg::ACT_RD |-> !overflow)
    else $error("overflow flagged on a read");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted transaction did not raise busy");
`endif

endmodule

/* sim/matrix4x4_arithmetic_unit_test.sv */
// Self-checking testbench for the 4x4 Q16.16 matrix arithmetic unit.
module matrix4x4_arithmetic_unit_test;
  import mxau_pkg::*;

  typedef struct {
    logic [3:0]         action;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct {
    logic signed [31:0] read_value;
    logic               overflow;
  } resp_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [3:0]         action;
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [31:0] value;
  logic               valid;
  logic signed [31:0] read_value;
  logic               overflow;

  cmd_t  cmd_q[$];
  resp_t resp_q[$];
  logic signed [31:0] mat_a[16];
  logic signed [31:0] mat_b[16];
  int    n_sent;
  int    n_checked;
  int    n_errors;
  int    n_ovf;
  bit    gen_done;
  bit    calm;

  matrix4x4_arithmetic_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .row(row), .col(col), .value(value),
    .valid(valid), .read_value(read_value), .overflow(overflow)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] s, inout logic ov);
    if (s > 66'sd2147483647) begin
      ov = 1'b1;
      return 32'sh7fffffff;
    end
    if (s < -66'sd2147483648) begin
      ov = 1'b1;
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // Fixed-point product: magnitude shifted down (toward zero), then saturated
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b, inout logic ov);
    logic [63:0]        mag;
    logic signed [65:0] r;
    mag = 64'(a < 0 ? -64'sd1 * a : a) * 64'(b < 0 ? -64'sd1 * b : b);
    mag = mag >> FRAC_BITS;
    r = ((a < 0) != (b < 0)) ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    return sat32(r, ov);
  endfunction

  // Apply one command to the shadow matrices and return its result
  function automatic resp_t apply_cmd(input cmd_t c);
    resp_t              r;
    logic               ov;
    logic signed [31:0] nxt[16];
    logic signed [65:0] acc;
    logic signed [31:0] t;
    int                 idx;
    idx = {c.row, c.col};
    ov = 1'b0;
    r.read_value = '0;
    case (c.action)
      ACT_WRA: mat_a[idx] = c.value;
      ACT_WRB: mat_b[idx] = c.value;
      ACT_RD:  r.read_value = mat_a[idx];
      ACT_ID:  for (int k = 0; k < 16; k++) mat_a[k] = (k % 5 == 0) ? ONE_Q : '0;
      ACT_TR: begin
        for (int i = 0; i < 4; i++)
          for (int j = i + 1; j < 4; j++) begin
            t = mat_a[i*4+j];
            mat_a[i*4+j] = mat_a[j*4+i];
            mat_a[j*4+i] = t;
          end
      end
      ACT_ADD, ACT_SUB: begin
        for (int k = 0; k < 16; k++) begin
          acc = (c.action == ACT_ADD) ? 66'(mat_a[k]) + 66'(mat_b[k])
                                      : 66'(mat_a[k]) - 66'(mat_b[k]);
          mat_a[k] = sat32(acc, ov);
        end
      end
      ACT_MUL: begin
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 4; j++) begin
            acc = '0;
            for (int k = 0; k < 4; k++)
              acc += 66'(fx_mul(mat_a[i*4+k], mat_b[k*4+j], ov));
            nxt[i*4+j] = sat32(acc, ov);
          end
        mat_a = nxt;
      end
      ACT_SCALE: for (int k = 0; k < 16; k++) mat_a[k] = fx_mul(mat_a[k], c.value, ov);
      default: ;
    endcase
    r.overflow = ov;
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_q();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      3: return $signed($urandom);
      default: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
    endcase
  endfunction

  function automatic cmd_t mk(input logic [3:0] a, input logic [1:0] r,
                              input logic [1:0] c, input logic signed [31:0] v);
    cmd_t x;
    x.action = a; x.row = r; x.col = c; x.value = v;
    return x;
  endfunction

  // Stimulus: directed corners, then well-formed random programs mixed with bursts of random raw commands
  initial begin
    cmd_t x;
    for (int k = 0; k < 16; k++) begin
      mat_a[k] = '0;
      mat_b[k] = '0;
    end
    cmd_q.push_back(mk(ACT_RD, 2'd3, 2'd3, '0));
    cmd_q.push_back(mk(ACT_WRA, 2'd0, 2'd0, 32'sh7fffffff));
    cmd_q.push_back(mk(ACT_WRA, 2'd3, 2'd3, 32'sh80000000));
    cmd_q.push_back(mk(ACT_WRA, 2'd3, 2'd2, 32'sh00018000));
    cmd_q.push_back(mk(ACT_WRB, 2'd0, 2'd0, 32'sh7fffffff));
    cmd_q.push_back(mk(ACT_WRB, 2'd3, 2'd3, 32'sh80000000));
    cmd_q.push_back(mk(ACT_ADD, 2'd0, 2'd0, '0));
    cmd_q.push_back(mk(ACT_RD, 2'd0, 2'd0, '0));
    cmd_q.push_back(mk(ACT_SUB, 2'd0, 2'd0, '0));
    cmd_q.push_back(mk(ACT_RD, 2'd3, 2'd2, '0));
    cmd_q.push_back(mk(ACT_TR, 2'd0, 2'd0, '0));
    cmd_q.push_back(mk(ACT_RD, 2'd2, 2'd3, '0));
    cmd_q.push_back(mk(ACT_SCALE, 2'd0, 2'd0, 32'sh80000000));
    cmd_q.push_back(mk(ACT_RD, 2'd3, 2'd3, '0));
    cmd_q.push_back(mk(ACT_ID, 2'd0, 2'd0, '0));
    cmd_q.push_back(mk(ACT_MUL, 2'd0, 2'd0, '0));
    cmd_q.push_back(mk(ACT_RD, 2'd3, 2'd3, '0));
    cmd_q.push_back(mk(ACT_SCALE, 2'd1, 2'd1, 32'sh00020000));
    cmd_q.push_back(mk(ACT_RD, 2'd3, 2'd3, '0));
    cmd_q.push_back(mk(4'd9, 2'd1, 2'd2, 32'sh12345678));
    cmd_q.push_back(mk(4'd15, 2'd3, 2'd3, 32'shffffffff));
    cmd_q.push_back(mk(ACT_MUL, 2'd0, 2'd0, '0));
    while (cmd_q.size() < 1250) begin
      if ($urandom_range(0, 9) < 8) begin
        // load both matrices, run a few operations, read everything back
        for (int k = 0; k < 16; k++) begin
          cmd_q.push_back(mk(ACT_WRA, k[3:2], k[1:0], rnd_q()));
          cmd_q.push_back(mk(ACT_WRB, k[3:2], k[1:0], rnd_q()));
        end
        repeat ($urandom_range(1, 3)) begin
          x = mk(4'($urandom_range(ACT_ID, ACT_SCALE)), 2'($urandom), 2'($urandom), rnd_q());
          cmd_q.push_back(x);
        end
        for (int k = 0; k < 16; k++)
          cmd_q.push_back(mk(ACT_RD, k[3:2], k[1:0], $signed($urandom)));
      end else begin
        repeat (10)
          cmd_q.push_back(mk(4'($urandom), 2'($urandom), 2'($urandom), $signed($urandom)));
      end
    end
    gen_done = 1'b1;
  end

  // Driver: one transaction at a time, random gaps except in a calm stretch
  // start rises only while busy is low, so it is always taken at the next rising edge
  always @(negedge clk) begin
    cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (start) begin
      start <= 1'b0;
    end else if (!busy && cmd_q.size() > 0) begin
      if (calm || $urandom_range(0, 99) >= 16) begin
        c = cmd_q.pop_front();
        resp_q.push_back(apply_cmd(c));
        action <= c.action;
        row    <= c.row;
        col    <= c.col;
        value  <= c.value;
        start  <= 1'b1;
        n_sent++;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    resp_t e;
    if (!rst && valid) begin
      if (resp_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result %h", read_value);
      end else begin
        e = resp_q.pop_front();
        n_checked++;
        if (overflow) n_ovf++;
        if (read_value !== e.read_value || overflow !== e.overflow) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d expected %h/%b got %h/%b", n_checked,
                     e.read_value, e.overflow, read_value, overflow);
        end
      end
    end
  end

  // Calm stretch with no driver gaps
  always @(posedge clk) calm <= (n_sent >= 400 && n_sent < 600);

  initial begin
    start = 1'b0; action = '0; row = '0; col = '0; value = '0;
    n_sent = 0; n_checked = 0; n_errors = 0; n_ovf = 0;
    wait (gen_done);
    wait (cmd_q.size() == 0 && !start && resp_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("Ran %0d transactions, %0d results checked, %0d with overflow.",
             n_sent, n_checked, n_ovf);
    if (n_errors == 0 && resp_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("Verification failed");
    $finish;
  end

endmodule
